// ===== hdl/text_console_glyph_renderer_top_assert.svh =====
// Assertion macros shared by the console renderer checkers.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TCGR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TCGR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tcgr_pkg.sv =====
// Shared types and constants for the text console glyph renderer.
// No dependencies; imported by the top level, its checker and the testbench files.
package tcgr_pkg;

	localparam int GLYPH_WIDTH = 8;
	localparam int CFG_DATA_W  = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int CUR_W       = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FB_BASE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COLOR   = 3'd4;

	localparam logic [CUR_W-1:0] RST_SCREEN_WIDTH  = 13'd1024;
	localparam logic [CUR_W-1:0] RST_SCREEN_HEIGHT = 13'd768;
	localparam logic [31:0]      RST_PIXEL_COLOR   = 32'h00FF_FFFF;

	// Text line height used for newline, wrap and scroll.
	localparam logic [CUR_W-1:0] LINE_STEP = 13'd16;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_CR      = 8'd13;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_FONT = 1'b1;

	localparam logic KIND_ROW    = 1'b0;
	localparam logic KIND_SCROLL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_SCROLL,
		ST_ROWS
	} tcgr_state_t;

endpackage

// ===== hdl/text_console_glyph_renderer_top.sv =====
// Text console glyph renderer: glyph memory, cursor and row-write sequencer.
// Depends on tcgr_pkg.
//
// One beat in at a time. A font load is done as it is accepted. A newline or
// carriage return is too, unless a scroll request has to go out first. A drawn
// character is accepted, then passes the row address multiply and base add
// steps, an optional scroll request and then one glyph row per cycle while the
// output is not stalled, GLYPH_HEIGHT in all; the single read port of the glyph
// memory sets that pace.
// in_ready is high only between characters; the last row beat may still sit
// in the output register while the next input is taken. The glyph memory has
// no reset, so a glyph row that was never loaded reads as garbage.
module text_console_glyph_renderer_top #(
	parameter int GLYPH_COUNT  = 256,
	parameter int GLYPH_HEIGHT = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [7:0]                      char_code,
	input  logic [11:0]                     font_index,
	input  logic [7:0]                      font_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            kind,
	output logic [47:0]                     row_addr,
	output logic [7:0]                      row_mask,
	output logic [31:0]                     write_color,
	output logic                            last,
	input  logic                            cfg_we,
	input  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tcgr_pkg::*;

	localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int ROW_W       = $clog2(GLYPH_HEIGHT);

	// configuration
	logic [47:0]      fb_base_q;
	logic [15:0]      row_pitch_q;
	logic [CUR_W-1:0] screen_width_q;
	logic [CUR_W-1:0] screen_height_q;
	logic [31:0]      pixel_color_q;

	// cursor and per-character work registers
	logic [CUR_W-1:0] cursor_col_q, cursor_row_q;
	logic [CUR_W-1:0] work_col_q, work_row_q;
	logic             drawn_q, scroll_q;
	logic [AW-1:0]    glyph_base_q;
	logic [ROW_W-1:0] row_q;
	logic [28:0]      prod_s1;
	logic [47:0]      addr_q;

	tcgr_state_t state_q, state_d;

	// glyph memory
	logic [7:0]    glyph_mem [STORE_DEPTH];
	logic [7:0]    rdata_s1;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          mem_we;

	// output register
	logic        out_valid_q, kind_q, last_q;
	logic [47:0] row_addr_q;
	logic [7:0]  row_mask_q;
	logic [31:0] write_color_q;

	logic             in_fire, char_fire, slot_free;
	logic             ld_scroll, ld_row, row_last;
	logic             is_drawn, need_scroll;
	logic [CUR_W-1:0] row_eff, col_eff, row_next_line;
	logic             wrap;
	logic [9:0]       code_ext, glyph_num;
	logic [AW-1:0]    glyph_base_d;
	logic [ROW_W-1:0] next_row;

	assign in_fire   = in_valid && in_ready;
	assign char_fire = in_fire && (op == OP_CHAR);
	assign slot_free = !out_valid_q || out_ready;
	assign row_last  = (row_q == ROW_W'(GLYPH_HEIGHT - 1));

	// cursor after an optional scroll, then its advance
	assign is_drawn      = (char_code != CHAR_NEWLINE) && (char_code != CHAR_CR);
	assign need_scroll   = (cursor_row_q >= screen_height_q);
	assign row_eff       = !need_scroll ? cursor_row_q :
	                       (screen_height_q >= LINE_STEP) ? screen_height_q - LINE_STEP :
	                       '0;
	assign col_eff       = need_scroll ? '0 : cursor_col_q;
	assign row_next_line = row_eff + LINE_STEP;
	assign wrap = ({1'b0, col_eff} + 14'(GLYPH_WIDTH)) >= {1'b0, screen_width_q};

	// code modulo GLYPH_COUNT: code is below twice the count
	assign code_ext     = 10'(char_code);
	assign glyph_num    = (code_ext >= 10'(GLYPH_COUNT)) ? code_ext - 10'(GLYPH_COUNT)
	                                                     : code_ext;
	assign glyph_base_d = AW'(32'(glyph_num) * GLYPH_HEIGHT);

	// read ahead: the address tracks the row that will be current next cycle
	assign next_row = (ld_row && !row_last) ? row_q + 1'b1 : row_q;
	assign rd_addr  = glyph_base_q + AW'(next_row);
	assign wr_addr  = AW'(font_index);
	assign mem_we   = in_fire && (op == OP_FONT) && (32'(font_index) < 32'(STORE_DEPTH));

	// writes only happen while idle; the read runs every cycle, but its data
	// is used only for row beats, while a character is busy
	always_ff @(posedge clk) begin
		if (mem_we) begin
			glyph_mem[wr_addr] <= font_byte;
		end
		rdata_s1 <= glyph_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ld_scroll = 1'b0;
		ld_row    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && op == OP_CHAR) begin
					if (is_drawn) begin
						state_d = ST_MUL;
					end else if (need_scroll) begin
						state_d = ST_SCROLL;
					end
				end
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = scroll_q ? ST_SCROLL : ST_ROWS;
			end
			ST_SCROLL: begin
				if (slot_free) begin
					ld_scroll = 1'b1;
					state_d   = drawn_q ? ST_ROWS : ST_IDLE;
				end
			end
			ST_ROWS: begin
				if (slot_free) begin
					ld_row = 1'b1;
					if (row_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// config, cursor and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_base_q       <= '0;
			row_pitch_q     <= '0;
			screen_width_q  <= RST_SCREEN_WIDTH;
			screen_height_q <= RST_SCREEN_HEIGHT;
			pixel_color_q   <= RST_PIXEL_COLOR;
			cursor_col_q    <= '0;
			cursor_row_q    <= '0;
			drawn_q         <= 1'b0;
			scroll_q        <= 1'b0;
			row_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FB_BASE:       fb_base_q       <= cfg_wdata;
					REG_ROW_PITCH:     row_pitch_q     <= cfg_wdata[15:0];
					REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata[CUR_W-1:0];
					REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata[CUR_W-1:0];
					REG_PIXEL_COLOR:   pixel_color_q   <= cfg_wdata[31:0];
					default: ;
				endcase
			end
			if (char_fire) begin
				drawn_q  <= is_drawn;
				scroll_q <= need_scroll;
				row_q    <= '0;
				if (char_code == CHAR_NEWLINE) begin
					cursor_col_q <= '0;
					cursor_row_q <= row_next_line;
				end else if (char_code == CHAR_CR) begin
					cursor_col_q <= '0;
					cursor_row_q <= row_eff;
				end else if (wrap) begin
					cursor_col_q <= '0;
					cursor_row_q <= row_next_line;
				end else begin
					cursor_col_q <= col_eff + CUR_W'(GLYPH_WIDTH);
					cursor_row_q <= row_eff;
				end
			end else begin
				row_q <= next_row;
			end
			if (ld_scroll || ld_row) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath and output payload
	always_ff @(posedge clk) begin
		if (char_fire) begin
			work_row_q   <= row_eff;
			work_col_q   <= col_eff;
			glyph_base_q <= glyph_base_d;
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= 29'(row_pitch_q) * 29'(work_row_q);
		end
		if (state_q == ST_ADD) begin
			addr_q <= fb_base_q + 48'(prod_s1) + 48'({work_col_q, 2'b00});
		end else if (ld_row) begin
			addr_q <= addr_q + 48'(row_pitch_q);
		end
		if (ld_scroll) begin
			kind_q        <= KIND_SCROLL;
			row_addr_q    <= fb_base_q;
			row_mask_q    <= '0;
			write_color_q <= '0;
			last_q        <= !drawn_q;
		end else if (ld_row) begin
			kind_q        <= KIND_ROW;
			row_addr_q    <= addr_q;
			row_mask_q    <= rdata_s1;
			write_color_q <= pixel_color_q;
			last_q        <= row_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign row_addr    = row_addr_q;
	assign row_mask    = row_mask_q;
	assign write_color = write_color_q;
	assign last        = last_q;

endmodule

// ===== hdl/tcgr_checker.sv =====
// Port-level checker for the text console glyph renderer, bound to the top.
// Depends on tcgr_pkg and text_console_glyph_renderer_top_assert.svh.
`include "text_console_glyph_renderer_top_assert.svh"

module tcgr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [47:0] row_addr,
	input logic [7:0]  row_mask,
	input logic [31:0] write_color,
	input logic        last
);
	import tcgr_pkg::*;

	// a stalled result beat holds
	`TCGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(row_addr) && $stable(row_mask) && $stable(last), "stalled result beat changed")

	// scroll requests carry the clear value and no mask
	`TCGR_ASSERT_NOW(a_scroll_clear, out_valid && kind == KIND_SCROLL, row_mask == 8'd0 && write_color == 32'd0, "scroll beat with nonzero mask or color")

	// no new input while a character still has beats to send
	`TCGR_ASSERT_NOW(a_busy_mid_char, out_valid && !last, !in_ready, "input taken in the middle of a character")

	// after a non-final scroll beat goes out, glyph rows follow, not idle
	`TCGR_ASSERT_NEXT(a_scroll_then_rows, out_valid && out_ready && kind == KIND_SCROLL && !last, !in_ready, "scroll without following rows")

endmodule

bind text_console_glyph_renderer_top tcgr_checker u_tcgr_checker (.*);

// ===== dv/glyph_row_checker.sv =====
// Scoreboard for the text console glyph renderer: predicts scroll and glyph row beats.
// Watches the input, output and register ports; depends on tcgr_pkg only.
module glyph_row_checker #(
	parameter int GLYPH_COUNT  = 256,
	parameter int GLYPH_HEIGHT = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            op,
	input  logic [7:0]                      char_code,
	input  logic [11:0]                     font_index,
	input  logic [7:0]                      font_byte,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            kind,
	input  logic [47:0]                     row_addr,
	input  logic [7:0]                      row_mask,
	input  logic [31:0]                     write_color,
	input  logic                            last,
	input  logic                            cfg_we,
	input  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              fails,
	output int                              pending,
	output int                              checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import tcgr_pkg::*;

	localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;

	typedef struct packed {
		logic        kind;
		logic [47:0] addr;
		logic [7:0]  mask;
		logic [31:0] color;
		logic        last;
	} row_beat_t;

	logic [7:0]       font_mem [STORE_DEPTH];
	logic [47:0]      sh_fb_base;
	logic [15:0]      sh_pitch;
	logic [CUR_W-1:0] sh_width;
	logic [CUR_W-1:0] sh_height;
	logic [31:0]      sh_color;
	logic [CUR_W-1:0] col_pos;
	logic [CUR_W-1:0] row_pos;
	row_beat_t        beats_due [$];

	task automatic report(input string msg);
		fails++;
		if (fails <= 40)
			$display("[%0t] mismatch on result beat %0d: %s", $realtime, checked, msg);
	endtask

	// Queue the beats one character causes and move the cursor.
	task automatic predict_char(input logic [7:0] code);
		logic        drawn;
		logic [63:0] addr_wide;
		int          glyph_base;
		int          i;
		drawn = (code != CHAR_NEWLINE) && (code != CHAR_CR);
		if (row_pos >= sh_height) begin
			beats_due.push_back('{KIND_SCROLL, sh_fb_base, 8'h00, 32'h0, !drawn});
			col_pos = '0;
			row_pos = (sh_height >= LINE_STEP) ? sh_height - LINE_STEP : '0;
		end
		if (code == CHAR_NEWLINE) begin
			col_pos = '0;
			row_pos = row_pos + LINE_STEP;
		end else if (code == CHAR_CR) begin
			col_pos = '0;
		end else begin
			glyph_base = (int'(code) % GLYPH_COUNT) * GLYPH_HEIGHT;
			for (i = 0; i < GLYPH_HEIGHT; i++) begin
				// row + i is not cut to 13 bits before the multiply
				addr_wide = 64'(sh_fb_base) + 64'(sh_pitch) * (64'(row_pos) + 64'(i))
					+ 64'(col_pos) * 64'd4;
				beats_due.push_back('{KIND_ROW, addr_wide[47:0], font_mem[glyph_base + i],
					sh_color, (i == GLYPH_HEIGHT - 1)});
			end
			if (32'(col_pos) + GLYPH_WIDTH >= 32'(sh_width)) begin
				col_pos = '0;
				row_pos = row_pos + LINE_STEP;
			end else begin
				col_pos = col_pos + CUR_W'(GLYPH_WIDTH);
			end
		end
	endtask

	always @(posedge clk) begin : watch
		row_beat_t exp_beat;
		if (!arst_n) begin
			sh_fb_base = '0;
			sh_pitch   = '0;
			sh_width   = RST_SCREEN_WIDTH;
			sh_height  = RST_SCREEN_HEIGHT;
			sh_color   = RST_PIXEL_COLOR;
			col_pos    = '0;
			row_pos    = '0;
			beats_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FB_BASE:       sh_fb_base = cfg_wdata[47:0];
					REG_ROW_PITCH:     sh_pitch   = cfg_wdata[15:0];
					REG_SCREEN_WIDTH:  sh_width   = cfg_wdata[CUR_W-1:0];
					REG_SCREEN_HEIGHT: sh_height  = cfg_wdata[CUR_W-1:0];
					REG_PIXEL_COLOR:   sh_color   = cfg_wdata[31:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (op == OP_FONT) begin
					if (32'(font_index) < STORE_DEPTH)
						font_mem[font_index] = font_byte;
				end else begin
					predict_char(char_code);
				end
			end
			if (out_valid && out_ready) begin
				checked++;
				if (beats_due.size() == 0) begin
					report($sformatf("unexpected beat kind %0b addr %h", kind, row_addr));
				end else begin
					exp_beat = beats_due.pop_front();
					if (kind !== exp_beat.kind)
						report($sformatf("kind got %b want %b", kind, exp_beat.kind));
					if (row_addr !== exp_beat.addr)
						report($sformatf("row_addr got %h want %h", row_addr, exp_beat.addr));
					if (row_mask !== exp_beat.mask)
						report($sformatf("row_mask got %h want %h", row_mask, exp_beat.mask));
					if (write_color !== exp_beat.color)
						report($sformatf("write_color got %h want %h", write_color,
							exp_beat.color));
					if (last !== exp_beat.last)
						report($sformatf("last got %b want %b", last, exp_beat.last));
				end
			end
		end
		pending <= beats_due.size();
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the glyph renderer testbench: clock, reset, register writes and beat traffic.
// Depends on tcgr_pkg, text_console_glyph_renderer_top and glyph_row_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tcgr_pkg::*;

	localparam int GLYPH_COUNT  = 256;
	localparam int GLYPH_HEIGHT = 16;
	localparam int DRAIN_CYCLES = 24;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  op;
	logic [7:0]            char_code;
	logic [11:0]           font_index;
	logic [7:0]            font_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic                  kind;
	logic [47:0]           row_addr;
	logic [7:0]            row_mask;
	logic [31:0]           write_color;
	logic                  last;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int fails;
	int pending;
	int checked;

	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int          sink_hold      = 0;

	int n_items    = 0;
	int n_chars    = 0;
	int n_font     = 0;
	int n_settings = 0;

	// glyph rows written so far; only fully written glyphs get drawn
	bit [GLYPH_HEIGHT-1:0] glyph_rows [GLYPH_COUNT];
	bit                    is_drawable [GLYPH_COUNT];
	logic [7:0]            drawable_codes [$];

	always #1 clk = ~clk;

	text_console_glyph_renderer_top #(
		.GLYPH_COUNT (GLYPH_COUNT),
		.GLYPH_HEIGHT(GLYPH_HEIGHT)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.char_code  (char_code),
		.font_index (font_index),
		.font_byte  (font_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.row_addr   (row_addr),
		.row_mask   (row_mask),
		.write_color(write_color),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	glyph_row_checker #(
		.GLYPH_COUNT (GLYPH_COUNT),
		.GLYPH_HEIGHT(GLYPH_HEIGHT)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.char_code  (char_code),
		.font_index (font_index),
		.font_byte  (font_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.row_addr   (row_addr),
		.row_mask   (row_mask),
		.write_color(write_color),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fails      (fails),
		.pending    (pending),
		.checked    (checked)
	);

	// Result side: random stalls, or a counted hold-off when sink_hold is set.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				sink_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	task automatic push_item(input logic item_op, input logic [7:0] code,
			input logic [11:0] idx, input logic [7:0] fbyte);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= item_op;
		char_code  <= code;
		font_index <= idx;
		font_byte  <= fbyte;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_items++;
	endtask

	task automatic send_char(input logic [7:0] code);
		push_item(OP_CHAR, code, 12'($urandom), 8'($urandom));
		n_chars++;
	endtask

	task automatic load_font_row(input logic [11:0] idx, input logic [7:0] fbyte);
		int g;
		push_item(OP_FONT, 8'($urandom), idx, fbyte);
		n_font++;
		g = int'(idx) / GLYPH_HEIGHT;
		glyph_rows[g][int'(idx) % GLYPH_HEIGHT] = 1'b1;
		if (&glyph_rows[g] && !is_drawable[g] && g != CHAR_NEWLINE && g != CHAR_CR) begin
			is_drawable[g] = 1'b1;
			drawable_codes.push_back(8'(g));
		end
	endtask

	task automatic load_glyph(input logic [7:0] code);
		int r;
		for (r = 0; r < GLYPH_HEIGHT; r++)
			load_font_row(12'(int'(code) * GLYPH_HEIGHT + r), 8'($urandom));
	endtask

	function automatic logic [7:0] any_glyph_code();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		while (c == CHAR_NEWLINE || c == CHAR_CR)
			c = 8'($urandom_range(255));
		return c;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [47:0] base, input logic [15:0] pitch,
			input logic [12:0] width, input logic [12:0] height, input logic [31:0] color);
		write_reg(REG_FB_BASE, base);
		write_reg(REG_ROW_PITCH, 48'(pitch));
		write_reg(REG_SCREEN_WIDTH, 48'(width));
		write_reg(REG_SCREEN_HEIGHT, 48'(height));
		write_reg(REG_PIXEL_COLOR, 48'(color));
		cfg_we <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	// Small screens most of the time so that wraps and scrolls come often.
	task automatic random_setting();
		logic [63:0] wide;
		logic [12:0] height;
		wide   = {$urandom, $urandom};
		height = ($urandom_range(3) == 0) ? 13'd4096 : 13'($urandom_range(80, 16));
		apply_setting(wide[47:0], 16'($urandom), 13'($urandom_range(96, 8)), height, $urandom);
	endtask

	// Stop offering and let every predicted beat drain out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_item();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 3)
			load_glyph(any_glyph_code());
		else if (pick < 22)
			load_font_row(12'($urandom), 8'($urandom));
		else if (pick < 32)
			send_char(CHAR_NEWLINE);
		else if (pick < 40)
			send_char(CHAR_CR);
		else
			send_char(drawable_codes[$urandom_range(drawable_codes.size() - 1)]);
	endtask

	initial begin : stimulus
		int ph;
		int start;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		op         <= OP_CHAR;
		char_code  <= '0;
		font_index <= '0;
		font_byte  <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_FB_BASE;
		cfg_wdata  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// font preload: both end glyphs
		load_glyph(8'd0);
		load_glyph(8'd255);

		// directed, reset register values
		load_font_row(12'd0, 8'h00);
		load_font_row(12'd15, 8'hFF);
		load_font_row(12'd4080, 8'h80);
		load_font_row(12'd4095, 8'h01);
		send_char(8'd0);
		send_char(8'd255);
		send_char(CHAR_CR);
		send_char(CHAR_NEWLINE);
		send_char(8'd255);

		// one glyph per line and one line per screen: scroll on most characters
		wait_idle();
		apply_setting(48'hFFFF_FFFF_FFFF, 16'hFFFF, 13'd8, 13'd16, 32'hFFFF_FFFF);
		send_char(8'd255);
		send_char(CHAR_NEWLINE);
		send_char(CHAR_CR);
		send_char(8'd0);
		send_char(8'd0);

		wait_idle();
		apply_setting(48'h0, 16'h0, 13'd4096, 13'd4096, 32'h0);
		send_char(8'd0);
		send_char(8'd255);
		send_char(CHAR_NEWLINE);
		send_char(8'd0);

		for (ph = 0; ph < 4; ph++) begin
			wait_idle();
			random_setting();
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
				default: begin src_idle_pct = 35; sink_stall_pct = 35; end
			endcase
			start = n_items;
			while (n_items - start < 36)
				random_item();
		end

		// long result hold-off while characters keep coming
		wait_idle();
		random_setting();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		sink_hold      = 400;
		repeat (12) send_char(drawable_codes[$urandom_range(drawable_codes.size() - 1)]);

		wait_idle();
		$display("Summary: %0d input beats (%0d characters, %0d font bytes), %0d screen setups",
			n_items, n_chars, n_font, n_settings);
		$display("Summary: %0d scroll and glyph row beats compared", checked);
		if (fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d result beats still outstanding", pending);
		$display("testbench NOT OK");
		$finish;
	end

endmodule
